### sv/lzbd_pkg.sv
// Package for the LZ bitstream decompressor: decode phases, sequencer modes
// and fixed field widths. No dependencies.
package lzbd_pkg;

   localparam int ByteW  = 8;
   localparam int WordW  = 64;
   localparam int CountW = 4;
   localparam int BufW   = 9;
   localparam int LenW   = 9;
   localparam int DistW  = 13;

   typedef enum logic [4:0] {
      PH_FIRST = 5'd0,
      PH_LIT   = 5'd1,
      PH_LITB  = 5'd2,
      PH_LEN1  = 5'd3,
      PH_LENS  = 5'd4,
      PH_LENE  = 5'd5,
      PH_LENF  = 5'd6,
      PH_RUN0  = 5'd7,
      PH_RUN1  = 5'd8,
      PH_RUN2  = 5'd9,
      PH_RUN3  = 5'd10,
      PH_RAW   = 5'd11,
      PH_LENB  = 5'd12,
      PH_LENX  = 5'd13,
      PH_EXT   = 5'd14,
      PH_EXIT  = 5'd15,
      PH_DIST  = 5'd16,
      PH_DP    = 5'd17,
      PH_DM    = 5'd18,
      PH_DX    = 5'd19,
      PH_DTERM = 5'd20,
      PH_DT    = 5'd21,
      PH_DLOW  = 5'd22,
      PH_DONE  = 5'd23
   } phase_type;

   typedef enum logic [2:0] {
      M_WAIT,
      M_RUN,
      M_CPRD,
      M_CPWR,
      M_FLUSH
   } mode_type;

endpackage

### sv/lzbd_if.sv
// Handshake interfaces for the decompressor's input and result channels.
// Depends on lzbd_pkg for field widths.
interface lzbd_req_if;
   import lzbd_pkg::*;
   logic              valid;
   logic              ready;
   logic [ByteW-1:0]  in_byte;
   logic              first_byte;
   modport source (output valid, in_byte, first_byte, input ready);
   modport sink   (input valid, in_byte, first_byte, output ready);
endinterface

interface lzbd_rsp_if;
   import lzbd_pkg::*;
   logic              valid;
   logic              ready;
   logic [WordW-1:0]  out_bytes;
   logic [CountW-1:0] byte_count;
   logic              last_of_run;
   logic              stream_end;
   modport source (output valid, out_bytes, byte_count, last_of_run, stream_end,
                   input ready);
   modport sink   (input valid, out_bytes, byte_count, last_of_run, stream_end,
                   output ready);
endinterface

### sv/lzbd_history.sv
// History memory of the decompressor: one write port, one read port with
// registered read data. No package dependencies.
module lzbd_history #(
   parameter int HISTORY_BYTES = 4096
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(HISTORY_BYTES)-1:0] wr_addr,
   input  logic [7:0]                       wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(HISTORY_BYTES)-1:0] rd_addr,
   output logic [7:0]                       rd_data
);
   logic [7:0] mem [HISTORY_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/lz_bitstream_decompressor_core.sv
// Top level of the LZ bitstream decompressor: bit decoder, match copy
// sequencer and result register. Depends on lzbd_pkg, lzbd_if, lzbd_history.
//
//   channel    dir   payload                                        accepted when
//   req_chan   in    in_byte, first_byte                            valid && ready
//   rsp_chan   out   out_bytes, byte_count, last_of_run, stream_end valid && ready
//
// An item is accepted in the wait mode; the sequencer then decodes its control bits
// and uses its data bytes one by one, and loads each result into the output register.
// A match copies each byte by the history memory's registered read followed by the
// write of the copied byte; a match is at most 263 bytes long.
// Reset is synchronous and clears all control state; the history is not cleared.
// A stalled result holds the sequencer only when the next result is due.
module lz_bitstream_decompressor_core #(
   parameter int HISTORY_BYTES = 4096,
   parameter int OUT_LANES     = 8
) (
   input  logic        clock,
   input  logic        reset,
   lzbd_req_if.sink    req_chan,
   lzbd_rsp_if.source  rsp_chan
);
   import lzbd_pkg::*;

   localparam int AW = $clog2(HISTORY_BYTES);
   localparam int PW = AW + 1;

   mode_type          mode_ff, mode_in, after_ff, after_in;
   phase_type         phase_ff, phase_in;
   logic [BufW-1:0]   bb_ff, bb_in;
   logic [LenW-1:0]   ml_ff, ml_in, rem_ff, rem_in;
   logic [3:0]        dh_ff, dh_in, rcb_ff, rcb_in;
   logic [6:0]        raw_ff, raw_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic              have_ff, have_in;
   logic [ByteW-1:0]  byte_ff, byte_in;
   logic [DistW-1:0]  dist_ff, dist_in;
   logic [WordW-1:0]  acc_ff, acc_in;
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic              lastf_ff, lastf_in, endf_ff, endf_in;

   logic              rsp_v_ff, rsp_v_in;
   logic [WordW-1:0]  o_bytes_ff, o_bytes_in;
   logic [CountW-1:0] o_cnt_ff, o_cnt_in;
   logic              o_last_ff, o_last_in, o_end_ff, o_end_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr, ptr_next;
   logic [7:0]        wr_data, rd_data;
   logic [PW-1:0]     ptr_w, dist_w;
   logic              out_free;
   logic              bit_v;
   logic              refill;

   lzbd_history #(.HISTORY_BYTES(HISTORY_BYTES)) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The history pointer wraps at the history size, which need not be a
   // power of two.
   assign ptr_next = (ptr_ff == AW'(HISTORY_BYTES - 1)) ? '0 : ptr_ff + 1'b1;
   assign ptr_w    = PW'(ptr_ff);
   assign dist_w   = PW'(dist_ff);
   assign rd_addr  = (ptr_w >= dist_w) ? AW'(ptr_w - dist_w)
                                       : AW'(ptr_w + PW'(HISTORY_BYTES) - dist_w);
   assign out_free = !rsp_v_ff || rsp_chan.ready;
   assign req_chan.ready = (mode_ff == M_WAIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_WAIT;
         after_ff <= M_WAIT;
         phase_ff <= PH_FIRST;
         bb_ff    <= '0;
         ml_ff    <= '0;
         rem_ff   <= '0;
         dh_ff    <= '0;
         rcb_ff   <= '0;
         raw_ff   <= '0;
         ptr_ff   <= '0;
         have_ff  <= 1'b0;
         cnt_ff   <= '0;
         acc_ff   <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         after_ff <= after_in;
         phase_ff <= phase_in;
         bb_ff    <= bb_in;
         ml_ff    <= ml_in;
         rem_ff   <= rem_in;
         dh_ff    <= dh_in;
         rcb_ff   <= rcb_in;
         raw_ff   <= raw_in;
         ptr_ff   <= ptr_in;
         have_ff  <= have_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      dist_ff    <= dist_in;
      lastf_ff   <= lastf_in;
      endf_ff    <= endf_in;
      o_bytes_ff <= o_bytes_in;
      o_cnt_ff   <= o_cnt_in;
      o_last_ff  <= o_last_in;
      o_end_ff   <= o_end_in;
   end

   always_comb begin
      mode_in    = mode_ff;
      after_in   = after_ff;
      phase_in   = phase_ff;
      bb_in      = bb_ff;
      ml_in      = ml_ff;
      rem_in     = rem_ff;
      dh_in      = dh_ff;
      rcb_in     = rcb_ff;
      raw_in     = raw_ff;
      ptr_in     = ptr_ff;
      have_in    = have_ff;
      byte_in    = byte_ff;
      dist_in    = dist_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      lastf_in   = lastf_ff;
      endf_in    = endf_ff;
      o_bytes_in = o_bytes_ff;
      o_cnt_in   = o_cnt_ff;
      o_last_in  = o_last_ff;
      o_end_in   = o_end_ff;
      rsp_v_in   = rsp_v_ff && !rsp_chan.ready;
      wr_en      = 1'b0;
      wr_addr    = ptr_ff;
      wr_data    = byte_ff;
      rd_en      = 1'b0;
      bit_v      = 1'b0;
      refill     = (bb_ff[6:0] == 7'd0);

      case (mode_ff)
         M_WAIT: begin
            if (req_chan.valid) begin
               if (req_chan.first_byte) begin
                  // Seeding restarts decoding; history and pointer are kept.
                  bb_in    = {req_chan.in_byte[6:0], 2'b10};
                  phase_in = PH_LIT;
                  ml_in    = '0;
                  dh_in    = '0;
                  rcb_in   = '0;
                  raw_in   = '0;
                  have_in  = 1'b0;
                  mode_in  = M_RUN;
               end else if (phase_ff != PH_FIRST && phase_ff != PH_DONE) begin
                  byte_in  = req_chan.in_byte;
                  have_in  = 1'b1;
                  mode_in  = M_RUN;
               end
            end
         end
         M_RUN: begin
            if (phase_ff == PH_LITB || phase_ff == PH_RAW ||
                phase_ff == PH_EXT || phase_ff == PH_DLOW) begin
               if (!have_ff) begin
                  mode_in = M_WAIT;
               end else begin
                  have_in = 1'b0;
                  case (phase_ff)
                     PH_LITB, PH_RAW: begin
                        wr_en    = 1'b1;
                        ptr_in   = ptr_next;
                        acc_in   = {{(WordW-ByteW){1'b0}}, byte_ff};
                        cnt_in   = CountW'(1);
                        lastf_in = 1'b1;
                        endf_in  = 1'b0;
                        after_in = M_RUN;
                        mode_in  = M_FLUSH;
                        if (phase_ff == PH_LITB) begin
                           phase_in = PH_LIT;
                        end else begin
                           raw_in = raw_ff - 1'b1;
                           if (raw_ff == 7'd1) begin
                              phase_in = PH_LIT;
                           end
                        end
                     end
                     PH_EXT: begin
                        if (byte_ff != '0) begin
                           ml_in    = LenW'(byte_ff) + LenW'(8);
                           phase_in = PH_DIST;
                        end else begin
                           phase_in = PH_EXIT;
                        end
                     end
                     default: begin
                        dist_in  = DistW'({dh_ff, byte_ff}) + 1'b1;
                        rem_in   = ml_ff;
                        phase_in = PH_LIT;
                        cnt_in   = '0;
                        acc_in   = '0;
                        mode_in  = (ml_ff == '0) ? M_RUN : M_CPRD;
                     end
                  endcase
               end
            end else if (phase_ff inside {[PH_LIT:PH_DT]}) begin
               if (refill && !have_ff) begin
                  mode_in = M_WAIT;
               end else begin
                  if (refill) begin
                     // Refill: the shifted-out bit joins the new byte.
                     have_in = 1'b0;
                     bb_in   = {byte_ff, bb_ff[7]};
                     bit_v   = byte_ff[7];
                  end else begin
                     bb_in   = {1'b0, bb_ff[6:0], 1'b0};
                     bit_v   = bb_ff[7];
                  end
                  case (phase_ff)
                     PH_LIT:  phase_in = bit_v ? PH_LEN1 : PH_LITB;
                     PH_LEN1: begin
                        ml_in    = LenW'(2);
                        dh_in    = '0;
                        phase_in = bit_v ? PH_LENB : PH_LENS;
                     end
                     PH_LENS: begin
                        ml_in    = LenW'(4) + LenW'(bit_v);
                        phase_in = PH_LENE;
                     end
                     PH_LENE: phase_in = bit_v ? PH_LENF : PH_DIST;
                     PH_LENF: begin
                        ml_in = {ml_ff[LenW-2:0] - 1'b1, bit_v};
                        if ({ml_ff[LenW-2:0] - 1'b1, bit_v} == LenW'(9)) begin
                           rcb_in   = '0;
                           phase_in = PH_RUN0;
                        end else begin
                           phase_in = PH_DIST;
                        end
                     end
                     PH_LENB: begin
                        if (bit_v) begin
                           ml_in    = LenW'(3);
                           phase_in = PH_LENX;
                        end else begin
                           phase_in = PH_DLOW;
                        end
                     end
                     PH_LENX: phase_in = bit_v ? PH_EXT : PH_DIST;
                     PH_EXIT: begin
                        if (bit_v) begin
                           phase_in = PH_LIT;
                        end else begin
                           // End of stream: one empty result marks it.
                           phase_in = PH_DONE;
                           acc_in   = '0;
                           cnt_in   = '0;
                           lastf_in = 1'b1;
                           endf_in  = 1'b1;
                           after_in = M_WAIT;
                           mode_in  = M_FLUSH;
                        end
                     end
                     PH_DIST: begin
                        dh_in    = '0;
                        phase_in = bit_v ? PH_DP : PH_DLOW;
                     end
                     PH_DP: begin
                        dh_in    = {3'b000, bit_v};
                        phase_in = PH_DM;
                     end
                     PH_DM: begin
                        if (bit_v) begin
                           phase_in = PH_DX;
                        end else if (dh_ff != '0) begin
                           phase_in = PH_DLOW;
                        end else begin
                           dh_in    = 4'd1;
                           phase_in = PH_DT;
                        end
                     end
                     PH_DX: begin
                        dh_in    = {dh_ff[2:0], bit_v} | 4'b0100;
                        phase_in = PH_DTERM;
                     end
                     PH_DTERM: phase_in = bit_v ? PH_DLOW : PH_DT;
                     PH_DT: begin
                        dh_in    = {dh_ff[2:0], bit_v};
                        phase_in = PH_DLOW;
                     end
                     default: begin
                        // Literal run length, four bits MSB first.
                        rcb_in = {rcb_ff[2:0], bit_v};
                        if (phase_ff == PH_RUN3) begin
                           raw_in   = {5'(rcb_in) + 5'd3, 2'b00};
                           phase_in = PH_RAW;
                        end else begin
                           phase_in = phase_type'(phase_ff + 1'b1);
                        end
                     end
                  endcase
               end
            end else begin
               have_in = 1'b0;
               mode_in = M_WAIT;
            end
         end
         M_CPRD: begin
            rd_en   = 1'b1;
            mode_in = M_CPWR;
         end
         M_CPWR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            ptr_in  = ptr_next;
            acc_in[8*cnt_ff[2:0] +: 8] = rd_data;
            cnt_in  = cnt_ff + 1'b1;
            rem_in  = rem_ff - 1'b1;
            if (rem_ff == LenW'(1) || cnt_ff == CountW'(OUT_LANES - 1)) begin
               lastf_in = (rem_ff == LenW'(1));
               endf_in  = 1'b0;
               after_in = (rem_ff == LenW'(1)) ? M_RUN : M_CPRD;
               mode_in  = M_FLUSH;
            end else begin
               mode_in  = M_CPRD;
            end
         end
         M_FLUSH: begin
            if (out_free) begin
               rsp_v_in   = 1'b1;
               o_bytes_in = acc_ff;
               o_cnt_in   = cnt_ff;
               o_last_in  = lastf_ff;
               o_end_in   = endf_ff;
               acc_in     = '0;
               cnt_in     = '0;
               mode_in    = after_ff;
            end
         end
         default: mode_in = M_WAIT;
      endcase
   end

   assign rsp_chan.valid       = rsp_v_ff;
   assign rsp_chan.out_bytes   = o_bytes_ff;
   assign rsp_chan.byte_count  = o_cnt_ff;
   assign rsp_chan.last_of_run = o_last_ff;
   assign rsp_chan.stream_end  = o_end_ff;
endmodule

### sv/lzbd_checker.sv
// Port-level checks on the decompressor's result channel, bound to the top
// level. Depends on lz_bitstream_decompressor_core.
module lzbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_out_bytes,
   input logic [3:0]  rsp_byte_count,
   input logic        rsp_last_of_run,
   input logic        rsp_stream_end
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_bytes)
         && $stable(rsp_byte_count))
      else $error("stalled result changed");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count <= 4'd8)
      else $error("byte count above eight");

   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_byte_count == 4'd0
         && rsp_out_bytes == 64'd0 && rsp_last_of_run)
      else $error("malformed end result");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_count == 4'd0 |-> rsp_stream_end)
      else $error("empty result without end of stream");
endmodule

bind lz_bitstream_decompressor_core lzbd_checker u_lzbd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_bytes   (rsp_chan.out_bytes),
   .rsp_byte_count  (rsp_chan.byte_count),
   .rsp_last_of_run (rsp_chan.last_of_run),
   .rsp_stream_end  (rsp_chan.stream_end)
);

### bench/lz_bitstream_decompressor_checker.sv
`timescale 1ns / 100ps
// Result checker for the LZ bitstream decompressor: watches both channels,
// decodes each accepted byte itself and compares the words that come out.
// Depends on lzbd_pkg and the channel interfaces in lzbd_if.
module lz_bitstream_decompressor_checker (
   input  logic clock,
   input  logic reset,
   lzbd_req_if  req,
   lzbd_rsp_if  rsp,
   output int   mismatches,
   output int   words_pending
);
   import lzbd_pkg::*;

   typedef struct packed {
      logic [WordW-1:0]  out_bytes;
      logic [CountW-1:0] byte_count;
      logic              last_of_run;
      logic              stream_end;
   } out_word_t;

   out_word_t         expected_words[$];

   logic [BufW-1:0]   bit_buf;
   phase_type         phase;
   logic [LenW-1:0]   copy_len;
   logic [3:0]        dist_high;
   logic [3:0]        run_bits;
   logic [6:0]        raw_left;
   logic [ByteW-1:0]  hist_mem[4096];
   logic [11:0]       hist_ptr;
   logic [ByteW-1:0]  decoded[$];
   bit                saw_end;

   assign words_pending = expected_words.size();

   function automatic void put_out(input logic [7:0] v);
      hist_mem[hist_ptr] = v;
      hist_ptr = hist_ptr + 12'd1;
      decoded.push_back(v);
   endfunction

   // Returns 0 when the buffer runs dry and the byte has already been used.
   function automatic bit pull_bit(inout bit have, input logic [7:0] cur, output bit b);
      logic [8:0] t;
      t = {bit_buf[7:0], 1'b0};
      b = t[8];
      if (t[7:0] == 8'd0) begin
         if (!have) return 0;
         have = 0;
         t = {cur, b};
         b = t[8];
      end
      bit_buf = t;
      return 1;
   endfunction

   function automatic void decode(input bit have_in, input logic [7:0] cur);
      bit         have;
      bit         b;
      bit         stop;
      phase_type  ph;
      logic [12:0] back_dist;
      logic [11:0] src;
      have = have_in;
      stop = 0;
      while (!stop) begin
         ph = phase;
         if (ph == PH_LITB || ph == PH_RAW || ph == PH_EXT || ph == PH_DLOW) begin
            if (!have) begin
               stop = 1;
            end else begin
               have = 0;
               case (ph)
                  PH_LITB: begin
                     put_out(cur);
                     phase = PH_LIT;
                  end
                  PH_RAW: begin
                     put_out(cur);
                     raw_left = raw_left - 7'd1;
                     if (raw_left == 7'd0) phase = PH_LIT;
                  end
                  PH_EXT: begin
                     if (cur != 8'd0) begin
                        copy_len = cur + 9'd8;
                        phase = PH_DIST;
                     end else begin
                        phase = PH_EXIT;
                     end
                  end
                  default: begin
                     back_dist = {1'b0, dist_high, cur} + 13'd1;
                     for (int i = 0; i < copy_len; i++) begin
                        src = hist_ptr - back_dist[11:0];
                        put_out(hist_mem[src]);
                     end
                     phase = PH_LIT;
                  end
               endcase
            end
         end else if (ph < PH_LIT || ph > PH_DT) begin
            stop = 1;
         end else if (!pull_bit(have, cur, b)) begin
            stop = 1;
         end else begin
            case (ph)
               PH_LIT:  phase = b ? PH_LEN1 : PH_LITB;
               PH_LEN1: begin
                  copy_len = 9'd2;
                  dist_high = 4'd0;
                  phase = b ? PH_LENB : PH_LENS;
               end
               PH_LENS: begin
                  copy_len = 9'd4 + b;
                  phase = PH_LENE;
               end
               PH_LENE: phase = b ? PH_LENF : PH_DIST;
               PH_LENF: begin
                  copy_len = b + 9'd2 * (copy_len - 9'd1);
                  if (copy_len == 9'd9) begin
                     run_bits = 4'd0;
                     phase = PH_RUN0;
                  end else begin
                     phase = PH_DIST;
                  end
               end
               PH_LENB: begin
                  if (b) begin
                     copy_len = 9'd3;
                     phase = PH_LENX;
                  end else begin
                     phase = PH_DLOW;
                  end
               end
               PH_LENX: phase = b ? PH_EXT : PH_DIST;
               PH_EXIT: begin
                  if (b) begin
                     phase = PH_LIT;
                  end else begin
                     saw_end = 1;
                     phase = PH_DONE;
                     stop = 1;
                  end
               end
               PH_DIST: begin
                  dist_high = 4'd0;
                  phase = b ? PH_DP : PH_DLOW;
               end
               PH_DP: begin
                  dist_high = {3'd0, b};
                  phase = PH_DM;
               end
               PH_DM: begin
                  if (b) begin
                     phase = PH_DX;
                  end else if (dist_high != 4'd0) begin
                     phase = PH_DLOW;
                  end else begin
                     dist_high = 4'd1;
                     phase = PH_DT;
                  end
               end
               PH_DX: begin
                  dist_high = {dist_high[2:0], b} | 4'd4;
                  phase = PH_DTERM;
               end
               PH_DTERM: phase = b ? PH_DLOW : PH_DT;
               PH_DT: begin
                  dist_high = {dist_high[2:0], b};
                  phase = PH_DLOW;
               end
               default: begin
                  run_bits = {run_bits[2:0], b};
                  if (ph == PH_RUN3) begin
                     raw_left = 7'd4 * (run_bits + 7'd3);
                     phase = PH_RAW;
                  end else begin
                     phase = phase_type'(ph + 5'd1);
                  end
               end
            endcase
         end
      end
   endfunction

   function automatic void take_byte(input logic [7:0] cur, input logic seed);
      out_word_t w;
      int        pos;
      int        cnt;
      decoded.delete();
      saw_end = 0;
      if (seed) begin
         bit_buf = {cur[6:0], 2'b10};
         phase = PH_LIT;
         copy_len = '0;
         dist_high = '0;
         run_bits = '0;
         raw_left = '0;
         decode(0, cur);
      end else if (phase != PH_FIRST && phase != PH_DONE) begin
         decode(1, cur);
      end
      pos = 0;
      while (pos < decoded.size()) begin
         cnt = decoded.size() - pos;
         if (cnt > 8) cnt = 8;
         w = '0;
         for (int i = 0; i < cnt; i++) w.out_bytes[8*i +: 8] = decoded[pos + i];
         pos += cnt;
         w.byte_count = 4'(cnt);
         w.last_of_run = (pos >= decoded.size()) && !saw_end;
         expected_words.push_back(w);
      end
      if (saw_end) begin
         w = '0;
         w.last_of_run = 1;
         w.stream_end = 1;
         expected_words.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      out_word_t got;
      out_word_t want;
      if (reset) begin
         bit_buf <= '0;
         phase <= PH_FIRST;
         copy_len <= '0;
         dist_high <= '0;
         run_bits <= '0;
         raw_left <= '0;
         hist_ptr <= '0;
         mismatches <= 0;
         expected_words.delete();
      end else begin
         if (req.valid && req.ready) take_byte(req.in_byte, req.first_byte);
         if (rsp.valid && rsp.ready) begin
            got = {rsp.out_bytes, rsp.byte_count, rsp.last_of_run, rsp.stream_end};
            if (expected_words.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result word with none expected: %h", $realtime, got);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch: bytes %h/%h count %0d/%0d last %b/%b end %b/%b",
                              $realtime, want.out_bytes, got.out_bytes, want.byte_count,
                              got.byte_count, want.last_of_run, got.last_of_run,
                              want.stream_end, got.stream_end);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

### bench/lz_bitstream_decompressor_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for lz_bitstream_decompressor_core: builds compressed streams,
// drives them in bursts and gives the verdict. Depends on lzbd_pkg, lzbd_if
// and lz_bitstream_decompressor_checker.
module lz_bitstream_decompressor_core_tb;
   import lzbd_pkg::*;

   // Cycles without any accepted item before the run is declared hung. Even
   // a 263-byte match hands out a result for every eight bytes it copies.
   localparam int IdleLimit = 5000;
   localparam int DrainCycles = 600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   words_pending;
   int   idle_cycles = 0;

   always #6 clock = ~clock;

   lzbd_req_if req_chan();
   lzbd_rsp_if rsp_chan();

   lz_bitstream_decompressor_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   lz_bitstream_decompressor_checker checker_0 (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .rsp           (rsp_chan),
      .mismatches    (mismatches),
      .words_pending (words_pending)
   );

   // The compressed stream is built up front as a list of items. Control bits
   // are packed the way the decoder pulls them: a refill byte is placed in the
   // stream at the moment its first bit is needed, so data bytes that follow
   // land after it, and the bits are filled in later, MSB first.
   logic [7:0] stream_bytes[$];
   bit         stream_seed[$];
   int         fill_slot;
   int         fill_left;
   int         hist_count;

   function automatic void put_bit(input bit b);
      logic [7:0] tmp;
      if (fill_left == 0) begin
         stream_bytes.push_back(8'd0);
         stream_seed.push_back(1'b0);
         fill_slot = stream_bytes.size() - 1;
         fill_left = 8;
      end
      tmp = stream_bytes[fill_slot];
      tmp[fill_left - 1] = b;
      stream_bytes[fill_slot] = tmp;
      fill_left--;
   endfunction

   function automatic void put_bits(input logic [7:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) put_bit(v[i]);
   endfunction

   function automatic void put_data(input logic [7:0] v);
      stream_bytes.push_back(v);
      stream_seed.push_back(1'b0);
   endfunction

   function automatic void add_output(input int n);
      hist_count += n;
      if (hist_count > 4096) hist_count = 4096;
   endfunction

   // The header byte holds six control bits; its top two bits are unused.
   function automatic void start_stream();
      stream_bytes.push_back({2'($urandom_range(0, 3)), 6'd0});
      stream_seed.push_back(1'b1);
      fill_slot = stream_bytes.size() - 1;
      fill_left = 6;
   endfunction

   function automatic void put_literal(input logic [7:0] v);
      put_bit(1'b0);
      put_data(v);
      add_output(1);
   endfunction

   function automatic void put_distance(input int distance);
      logic [11:0] d;
      logic [3:0]  h;
      logic [2:0]  h2;
      d = 12'(distance - 1);
      h = d[11:8];
      h2 = h[3:1];
      if (h == 4'd0)      put_bit(1'b0);
      else if (h == 4'd1) put_bits(8'b110, 3);
      else if (h < 4'd4)  put_bits({4'd0, 3'b100, h[0]}, 4);
      else if (h < 4'd8)  put_bits({3'd0, 1'b1, h[1], 1'b1, h[0], 1'b1}, 5);
      else                put_bits({2'd0, 1'b1, h2[1], 1'b1, h2[0], 1'b0, h[0]}, 6);
      put_data(d[7:0]);
   endfunction

   // A match of len bytes, 2 to 263; a length of 2 reaches back 256 at most.
   function automatic void put_match(input int len, input int distance);
      put_bit(1'b1);
      if (len == 2) begin
         put_bits(8'b10, 2);
         put_data(8'(distance - 1));
      end else begin
         if (len == 3) begin
            put_bits(8'b110, 3);
         end else if (len < 6) begin
            put_bits({6'd0, 1'b0, 1'(len - 4)}, 2);
            put_bit(1'b0);
         end else if (len < 8) begin
            put_bits({4'd0, 3'b001, 1'(len - 6)}, 4);
         end else if (len == 8) begin
            put_bits(8'b0110, 4);
         end else begin
            put_bits(8'b111, 3);
            put_data(8'(len - 8));
         end
         put_distance(distance);
      end
      add_output(len);
   endfunction

   // A literal run of 4 * (count + 3) raw bytes.
   function automatic void put_run(input int count);
      put_bits(8'b10111, 5);
      put_bits(8'(count), 4);
      for (int i = 0; i < 4 * (count + 3); i++) put_data(8'($urandom_range(0, 255)));
      add_output(4 * (count + 3));
   endfunction

   // An extended length byte of zero, then the bit that ends or goes on.
   function automatic void put_exit(input bit go_on);
      put_bits(8'b1111, 4);
      put_data(8'd0);
      put_bit(go_on);
   endfunction

   function automatic void put_noise(input int n);
      for (int i = 0; i < n; i++) put_data(8'($urandom_range(0, 255)));
   endfunction

   function automatic void put_random_match();
      int len;
      int top;
      int distance;
      case ($urandom_range(0, 9))
         0, 1:    len = 2;
         2:       len = 3;
         3, 4:    len = $urandom_range(4, 5);
         5, 6:    len = $urandom_range(6, 8);
         7, 8:    len = $urandom_range(9, 24);
         default: len = $urandom_range(9, 263);
      endcase
      top = (len == 2 && hist_count > 256) ? 256 : hist_count;
      if (top == 0) begin
         put_literal(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 2) == 0) distance = $urandom_range(1, top);
         else distance = $urandom_range(1, top < 16 ? top : 16);
         put_match(len, distance);
      end
   endfunction

   function automatic void build_directed();
      put_noise(3);                     // ignored: nothing seeded yet
      start_stream();
      put_literal(8'h00);
      put_literal(8'hFF);
      put_match(2, 1);
      put_match(3, 2);
      put_match(4, 4);
      put_match(5, 1);
      put_match(6, 3);
      put_match(7, 5);
      put_match(8, 2);
      put_run(0);
      put_match(263, hist_count);       // longest match from the oldest byte
      put_match(9, 300);                // high distance of one
      put_exit(1'b1);                   // zero extended length, stream goes on
      put_literal(8'h5A);
      put_match(264 - 8 - 1, 1);
      put_exit(1'b0);                   // end of stream
      put_noise(2);                     // ignored after the end
      start_stream();
      put_literal(8'hA5);
      put_bits(8'b1110, 4);             // match cut short by a new header byte
      start_stream();
      put_literal(8'h3C);
      put_exit(1'b0);
   endfunction

   function automatic void build_random(input int target);
      int tokens;
      while (stream_bytes.size() < target) begin
         start_stream();
         tokens = $urandom_range(2, 10);
         for (int i = 0; i < tokens; i++) begin
            case ($urandom_range(0, 19))
               0, 1:          put_run($urandom_range(0, 5) == 0 ? $urandom_range(0, 15) : 0);
               2, 3, 4, 5, 6,
               7, 8, 9:       put_random_match();
               10:            put_exit(1'b1);
               default:       put_literal(8'($urandom_range(0, 255)));
            endcase
         end
         // Most streams end properly; the rest are cut off by the next header.
         if ($urandom_range(0, 9) < 7) begin
            put_exit(1'b0);
            put_noise($urandom_range(0, 2));
         end
      end
   endfunction

   // The receiver alternates between stretches of full throughput and
   // stretches where it stalls about a quarter of the time.
   int rsp_cycle = 0;
   always @(negedge clock) begin
      rsp_cycle++;
      if (reset) rsp_chan.ready = 1'b0;
      else if ((rsp_cycle / 150) % 2 == 0) rsp_chan.ready = 1'b1;
      else rsp_chan.ready = ($urandom_range(0, 3) != 0);
   end

   // Watchdog on accepted items of either channel.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      int burst_left;
      int gap;
      req_chan.valid = 1'b0;
      req_chan.in_byte = '0;
      req_chan.first_byte = 1'b0;
      hist_count = 0;
      fill_left = 0;
      build_directed();
      build_random(130);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Items go out in bursts of random length separated by random gaps;
      // a zero gap merges two bursts into one long stretch.
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < stream_bytes.size(); i++) begin
         @(negedge clock);
         req_chan.valid = 1'b1;
         req_chan.in_byte = stream_bytes[i];
         req_chan.first_byte = stream_seed[i];
         do @(posedge clock); while (!req_chan.ready);
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               @(negedge clock);
               req_chan.valid = 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
      end
      @(negedge clock);
      req_chan.valid = 1'b0;

      while (words_pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatches == 0 && words_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### sim.f
sv/lzbd_pkg.sv
sv/lzbd_if.sv
sv/lzbd_history.sv
sv/lz_bitstream_decompressor_core.sv
sv/lzbd_checker.sv
bench/lz_bitstream_decompressor_checker.sv
bench/lz_bitstream_decompressor_core_tb.sv
